// ----- design/dgr_pkg.sv -----
// shared types and codes for the digraph reachability and cycle checker
package dgr_pkg;

	// command codes carried in the input tuser
	localparam logic [1:0] CMD_ADD_EDGE = 2'd0;
	localparam logic [1:0] CMD_EVALUATE = 2'd1;
	localparam logic [1:0] CMD_CLEAR    = 2'd2;

	// verdict codes
	localparam logic [1:0] VERD_REACHED_ACYCLIC = 2'd0;
	localparam logic [1:0] VERD_REACHED_CYCLIC  = 2'd1;
	localparam logic [1:0] VERD_UNREACHED       = 2'd2;

	// field widths fixed by the interface
	localparam int VTX_W = 10;
	localparam int CNT_W = 11;

	// one input beat
	typedef struct packed {
		logic [1:0]       cmd;
		logic [VTX_W-1:0] from_vertex;
		logic [VTX_W-1:0] to_vertex;
	} item_t;

	// one result beat
	typedef struct packed {
		logic [1:0] verdict;
		logic       target_reached;
		logic       cycle_found;
		logic       edge_overflow;
	} result_t;

endpackage

// ----- design/dgr_ram.sv -----
// generic simple dual-port ram with registered read
module dgr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/dgr_ctrl.sv -----
// graph store, mark store, walk stack and the sequencer that walks them
module dgr_ctrl #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_DEGREE   = 4
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  dgr_pkg::item_t                     item,
	input  logic [$clog2(MAX_VERTICES+1)-1:0]  n_use,
	input  logic                               res_free,
	output logic                               idle,
	output logic                               done,
	output dgr_pkg::result_t                   res
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int NW = $clog2(MAX_VERTICES + 1);
	localparam int KW = $clog2(MAX_DEGREE + 1);
	localparam int AW = $clog2(MAX_VERTICES * MAX_DEGREE);
	localparam int SW = VW + 2 * KW;
	localparam int XW = dgr_pkg::VTX_W;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_CLRD = 4'd1;
	localparam logic [3:0] S_ADD  = 4'd2;
	localparam logic [3:0] S_CLRM = 4'd3;
	localparam logic [3:0] S_INIT = 4'd4;
	localparam logic [3:0] S_DEG  = 4'd5;
	localparam logic [3:0] S_EDGE = 4'd6;
	localparam logic [3:0] S_ADJ  = 4'd7;
	localparam logic [3:0] S_MARK = 4'd8;
	localparam logic [3:0] S_POP  = 4'd9;
	localparam logic [3:0] S_FIN  = 4'd10;

	logic [3:0]    state_q;
	logic [VW-1:0] cnt_q;
	logic [VW-1:0] v_q;
	logic [KW-1:0] k_q;
	logic [KW-1:0] deg_q;
	logic [NW-1:0] depth_q;
	logic [XW-1:0] w_q;
	logic [VW-1:0] from_q;
	logic [XW-1:0] to_q;
	logic          reached_q;
	logic          cycle_q;
	logic          ovf_q;

	logic          deg_we;
	logic [VW-1:0] deg_waddr, deg_raddr;
	logic [KW-1:0] deg_wdata, deg_rdata;
	logic          adj_we;
	logic [AW-1:0] adj_waddr, adj_raddr;
	logic [XW-1:0] adj_wdata, adj_rdata;
	logic          mark_we;
	logic [VW-1:0] mark_waddr, mark_raddr;
	logic [1:0]    mark_wdata, mark_rdata;
	logic          stk_we;
	logic [VW-1:0] stk_waddr, stk_raddr;
	logic [SW-1:0] stk_wdata, stk_rdata;

	logic          in_range;
	logic          has_edge;
	logic          w_ok;
	logic          deg_full;
	logic [NW-1:0] depth_m1, depth_m2;
	logic [NW-1:0] n_m1;

	// decoded conditions
	assign in_range = (32'(item.from_vertex) < MAX_VERTICES)
		&& (32'(item.to_vertex) < MAX_VERTICES);
	assign has_edge = k_q < deg_q;
	assign w_ok     = 32'(adj_rdata) < 32'(n_use);
	assign deg_full = 32'(deg_rdata) >= MAX_DEGREE;
	assign depth_m1 = depth_q - NW'(1);
	assign depth_m2 = depth_q - NW'(2);
	assign n_m1     = n_use - NW'(1);

	// memory port control
	always_comb begin
		deg_we     = 1'b0;
		deg_waddr  = cnt_q;
		deg_wdata  = '0;
		deg_raddr  = VW'(item.from_vertex);
		adj_we     = 1'b0;
		adj_waddr  = AW'(from_q) * AW'(MAX_DEGREE) + AW'(deg_rdata);
		adj_wdata  = to_q;
		adj_raddr  = AW'(v_q) * AW'(MAX_DEGREE) + AW'(k_q);
		mark_we    = 1'b0;
		mark_waddr = cnt_q;
		mark_wdata = 2'b00;
		mark_raddr = VW'(adj_rdata);
		stk_we     = 1'b0;
		stk_waddr  = depth_m1[VW-1:0];
		stk_wdata  = {v_q, k_q, deg_q};
		stk_raddr  = depth_m2[VW-1:0];
		unique case (state_q)
			S_CLRD: begin
				deg_we = 1'b1;
			end
			S_ADD: begin
				if (!deg_full) begin
					adj_we    = 1'b1;
					deg_we    = 1'b1;
					deg_waddr = from_q;
					deg_wdata = deg_rdata + KW'(1);
				end
			end
			S_CLRM: begin
				mark_we = 1'b1;
			end
			S_INIT: begin
				mark_we    = 1'b1;
				mark_waddr = '0;
				mark_wdata = 2'b11;
				deg_raddr  = '0;
			end
			S_EDGE: begin
				// finished vertex leaves the stack but stays visited
				if (!has_edge) begin
					mark_we    = 1'b1;
					mark_waddr = v_q;
					mark_wdata = 2'b10;
				end
			end
			S_MARK: begin
				deg_raddr = VW'(w_q);
				if (!mark_rdata[1]) begin
					mark_we    = 1'b1;
					mark_waddr = VW'(w_q);
					mark_wdata = 2'b11;
					stk_we     = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// sequencer control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_CLRD;
			cnt_q     <= '0;
			depth_q   <= '0;
			reached_q <= 1'b0;
			cycle_q   <= 1'b0;
			ovf_q     <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						unique case (item.cmd)
							dgr_pkg::CMD_ADD_EDGE: begin
								if (in_range) begin
									state_q <= S_ADD;
								end
							end
							dgr_pkg::CMD_EVALUATE: state_q <= S_CLRM;
							dgr_pkg::CMD_CLEAR: begin
								ovf_q   <= 1'b0;
								state_q <= S_CLRD;
							end
							default: begin
							end
						endcase
					end
				end
				S_CLRD: begin
					if (cnt_q == VW'(MAX_VERTICES - 1)) begin
						state_q <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + VW'(1);
					end
				end
				S_ADD: begin
					if (deg_full) begin
						ovf_q <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_CLRM: begin
					if (NW'(cnt_q) == n_m1) begin
						state_q <= S_INIT;
					end else begin
						cnt_q <= cnt_q + VW'(1);
					end
				end
				S_INIT: begin
					depth_q   <= NW'(1);
					reached_q <= (n_use == NW'(1));
					cycle_q   <= 1'b0;
					state_q   <= S_DEG;
				end
				S_DEG: state_q <= S_EDGE;
				S_EDGE: begin
					if (has_edge) begin
						state_q <= S_ADJ;
					end else begin
						depth_q <= depth_m1;
						state_q <= (depth_q == NW'(1)) ? S_FIN : S_POP;
					end
				end
				S_ADJ: state_q <= w_ok ? S_MARK : S_EDGE;
				S_MARK: begin
					if (!mark_rdata[1]) begin
						depth_q <= depth_q + NW'(1);
						if (32'(w_q) == 32'(n_m1)) begin
							reached_q <= 1'b1;
						end
						state_q <= S_DEG;
					end else begin
						if (mark_rdata[0]) begin
							cycle_q <= 1'b1;
						end
						state_q <= S_EDGE;
					end
				end
				S_POP: state_q <= S_EDGE;
				S_FIN: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// walk payload registers
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			from_q <= VW'(item.from_vertex);
			to_q   <= item.to_vertex;
		end
		unique case (state_q)
			S_INIT: begin
				v_q <= '0;
				k_q <= '0;
			end
			S_DEG: deg_q <= deg_rdata;
			S_EDGE: begin
				if (has_edge) begin
					k_q <= k_q + KW'(1);
				end
			end
			S_ADJ: w_q <= adj_rdata;
			S_MARK: begin
				if (!mark_rdata[1]) begin
					v_q <= VW'(w_q);
					k_q <= '0;
				end
			end
			S_POP: {v_q, k_q, deg_q} <= stk_rdata;
			default: begin
			end
		endcase
	end

	// per-vertex out-degree
	dgr_ram #(.WIDTH(KW), .DEPTH(MAX_VERTICES)) u_deg (
		.clk(clk), .we(deg_we), .waddr(deg_waddr), .wdata(deg_wdata),
		.raddr(deg_raddr), .rdata(deg_rdata)
	);

	// adjacency lists, MAX_DEGREE slots per vertex
	dgr_ram #(.WIDTH(XW), .DEPTH(MAX_VERTICES * MAX_DEGREE)) u_adj (
		.clk(clk), .we(adj_we), .waddr(adj_waddr), .wdata(adj_wdata),
		.raddr(adj_raddr), .rdata(adj_rdata)
	);

	// visited and on-stack marks
	dgr_ram #(.WIDTH(2), .DEPTH(MAX_VERTICES)) u_mark (
		.clk(clk), .we(mark_we), .waddr(mark_waddr), .wdata(mark_wdata),
		.raddr(mark_raddr), .rdata(mark_rdata)
	);

	// saved levels below the top of the walk
	dgr_ram #(.WIDTH(SW), .DEPTH(MAX_VERTICES)) u_stk (
		.clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
		.raddr(stk_raddr), .rdata(stk_rdata)
	);

	// status and result
	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_FIN) && res_free;
	assign res.verdict = reached_q
		? (cycle_q ? dgr_pkg::VERD_REACHED_CYCLIC : dgr_pkg::VERD_REACHED_ACYCLIC)
		: dgr_pkg::VERD_UNREACHED;
	assign res.target_reached = reached_q;
	assign res.cycle_found    = cycle_q;
	assign res.edge_overflow  = ovf_q;

endmodule

// ----- design/digraph_reach_cycle_check.sv -----
// Directed graph reachability and cycle check, top level with stream ports.
// Add edge: out-degree read, then store write. Clear: sweeps every out-degree entry and the overflow flag.
// Evaluate: clear the marks of the n used vertices, then walk depth-first from vertex 0
// through the registered reads of the mark, degree and stack rams.
// One item at a time; the result register frees the walk as soon as it is loaded.
// Reset sweeps all MAX_VERTICES entries of the out-degree ram with s_axis_tready low.
module digraph_reach_cycle_check #(
	parameter int MAX_VERTICES = 1024,
	parameter int MAX_DEGREE   = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,  // from_vertex[9:0], to_vertex[19:10], zero
	input  logic [1:0]  s_axis_tuser,  // cmd[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,  // verdict[1:0], target_reached[2],
	                                   // cycle_found[3], edge_overflow[4], zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data       // vertex_count[10:0]
);

	localparam int NW = $clog2(MAX_VERTICES + 1);

	logic [NW-1:0]       n_use_q;
	logic                out_valid_q;
	dgr_pkg::result_t    out_res_q;
	dgr_pkg::item_t      item;
	dgr_pkg::result_t    res;
	logic                idle, done, res_free, start;

	assign item.cmd         = s_axis_tuser;
	assign item.from_vertex = s_axis_tdata[9:0];
	assign item.to_vertex   = s_axis_tdata[19:10];
	assign s_axis_tready    = idle;
	assign start            = s_axis_tvalid && idle;
	assign res_free         = !out_valid_q || m_axis_tready;
	assign cfg_ready        = 1'b1;

	// vertex count, clamped to 1..MAX_VERTICES on write
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_use_q <= NW'(1);
		end else if (cfg_valid) begin
			if (cfg_data == '0) begin
				n_use_q <= NW'(1);
			end else if (32'(cfg_data) > MAX_VERTICES) begin
				n_use_q <= NW'(MAX_VERTICES);
			end else begin
				n_use_q <= NW'(cfg_data);
			end
		end
	end

	dgr_ctrl #(.MAX_VERTICES(MAX_VERTICES), .MAX_DEGREE(MAX_DEGREE)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .item(item), .n_use(n_use_q),
		.res_free(res_free), .idle(idle), .done(done), .res(res)
	);

	// result beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {3'b000, out_res_q.edge_overflow,
		out_res_q.cycle_found, out_res_q.target_reached, out_res_q.verdict};

	// a result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !out_valid_q || m_axis_tready)
		else $error("result overwritten");

	// verdict agrees with the reached and cycle bits
	a_verdict: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[2] ? (m_axis_tdata[1:0] == {1'b0, m_axis_tdata[3]})
		: (m_axis_tdata[1:0] == dgr_pkg::VERD_UNREACHED)))
		else $error("verdict inconsistent");

	// vertex count stays within range
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(n_use_q != '0) && (32'(n_use_q) <= MAX_VERTICES))
		else $error("vertex count out of range");

	// result beat holds while the receiver stalls
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

endmodule

// ----- test/tb_top.sv -----
// testbench for the digraph reachability and cycle checker
`timescale 1ns / 1ps
module tb_top;

	localparam int NV = 1024;
	localparam int ND = 4;
	localparam longint CYCLE_LIMIT = 64'd20000000;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [10:0] cfg_data;

	// golden graph state
	logic [9:0]  adj [NV*ND];
	int unsigned deg [NV];
	bit          ovf;
	logic [10:0] vcount;
	bit          vis [NV];
	bit          onstk [NV];
	int unsigned stk_v [NV];
	int unsigned stk_k [NV];

	dgr_pkg::result_t verdict_q [$];
	int          errors;
	longint      cycles;
	bit          src_idle_en;
	bit          snk_idle_en;
	int          hold_cycles;

	digraph_reach_cycle_check u_top (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #4;
		clk = 1'b1; #4;
	end

	// cycle count and timeout
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// depth-first walk from vertex 0, returns the expected result
	function automatic dgr_pkg::result_t eval_graph();
		int unsigned n, depth, v, k, w;
		bit cyc, reached;
		dgr_pkg::result_t r;
		n = (vcount == 0) ? 1 : ((vcount > NV) ? NV : vcount);
		for (int i = 0; i < NV; i++) begin
			vis[i] = 0;
			onstk[i] = 0;
		end
		cyc = 0;
		vis[0] = 1; onstk[0] = 1; stk_v[0] = 0; stk_k[0] = 0; depth = 1;
		while (depth > 0) begin
			v = stk_v[depth-1];
			k = stk_k[depth-1];
			if (k < deg[v]) begin
				w = adj[v*ND+k];
				stk_k[depth-1] = k + 1;
				if (w < n) begin
					if (!vis[w]) begin
						vis[w] = 1; onstk[w] = 1;
						if (depth < NV) begin
							stk_v[depth] = w; stk_k[depth] = 0; depth++;
						end
					end else if (onstk[w]) cyc = 1;
				end
			end else begin
				onstk[v] = 0;
				depth--;
			end
		end
		reached = vis[n-1];
		r.verdict = reached
			? (cyc ? dgr_pkg::VERD_REACHED_CYCLIC : dgr_pkg::VERD_REACHED_ACYCLIC)
			: dgr_pkg::VERD_UNREACHED;
		r.target_reached = reached;
		r.cycle_found = cyc;
		r.edge_overflow = ovf;
		return r;
	endfunction

	// apply one accepted item to the golden state
	function automatic void apply_item(logic [1:0] cmd, logic [9:0] f, logic [9:0] t);
		case (cmd)
			dgr_pkg::CMD_ADD_EDGE: begin
				if (deg[f] >= ND) ovf = 1;
				else begin
					adj[f*ND+deg[f]] = t;
					deg[f]++;
				end
			end
			dgr_pkg::CMD_CLEAR: begin
				for (int i = 0; i < NV; i++) deg[i] = 0;
				ovf = 0;
			end
			dgr_pkg::CMD_EVALUATE: verdict_q.push_back(eval_graph());
			default: ;
		endcase
	endfunction

	// send one item, with random idle before it
	task automatic send_item(logic [1:0] cmd, int unsigned f, int unsigned t);
		while (src_idle_en && $urandom_range(99) < 12) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= cmd;
		s_axis_tdata <= {4'd0, 10'(t), 10'(f)};
		do @(posedge clk); while (!s_axis_tready);
		apply_item(cmd, 10'(f), 10'(t));
	endtask

	// wait until every verdict is back, then let the walk settle
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0) @(posedge clk);
		repeat (3000) @(posedge clk);
	endtask

	task automatic write_count(logic [10:0] value);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		vcount = value;
		cfg_valid <= 1'b0;
	endtask

	// sink side: random stall, with one long hold-off
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			m_axis_tready <= 1'b0;
		end else m_axis_tready <= !(snk_idle_en && $urandom_range(99) < 12);
	end

	// compare each result beat with the oldest expected verdict
	always @(posedge clk) begin
		dgr_pkg::result_t got, exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.verdict = m_axis_tdata[1:0];
			got.target_reached = m_axis_tdata[2];
			got.cycle_found = m_axis_tdata[3];
			got.edge_overflow = m_axis_tdata[4];
			if (verdict_q.size() == 0) begin
				$display("%0t unexpected result, exp none act %h", $time, got);
				errors++;
			end else begin
				exp_r = verdict_q.pop_front();
				if (got.verdict !== exp_r.verdict) begin
					$display("%0t verdict exp %0d act %0d", $time, exp_r.verdict, got.verdict);
					errors++;
				end
				if (got.target_reached !== exp_r.target_reached) begin
					$display("%0t target_reached exp %0d act %0d", $time,
						exp_r.target_reached, got.target_reached);
					errors++;
				end
				if (got.cycle_found !== exp_r.cycle_found) begin
					$display("%0t cycle_found exp %0d act %0d", $time,
						exp_r.cycle_found, got.cycle_found);
					errors++;
				end
				if (got.edge_overflow !== exp_r.edge_overflow) begin
					$display("%0t edge_overflow exp %0d act %0d", $time,
						exp_r.edge_overflow, got.edge_overflow);
					errors++;
				end
			end
		end
	end

	// small fixed graphs: chain, self loop, overflow, clear, unused command
	task automatic test_directed();
		write_count(11'd4);
		send_item(dgr_pkg::CMD_EVALUATE, 0, 0);
		send_item(dgr_pkg::CMD_ADD_EDGE, 0, 1);
		send_item(dgr_pkg::CMD_ADD_EDGE, 1, 2);
		send_item(dgr_pkg::CMD_ADD_EDGE, 2, 3);
		send_item(dgr_pkg::CMD_EVALUATE, 0, 0);
		send_item(dgr_pkg::CMD_ADD_EDGE, 3, 1);
		send_item(dgr_pkg::CMD_EVALUATE, 0, 0);
		send_item(dgr_pkg::CMD_ADD_EDGE, 2, 1023);
		send_item(dgr_pkg::CMD_ADD_EDGE, 2, 2);
		send_item(dgr_pkg::CMD_ADD_EDGE, 2, 0);
		send_item(dgr_pkg::CMD_ADD_EDGE, 2, 3);
		send_item(dgr_pkg::CMD_EVALUATE, 0, 0);
		send_item(2'd3, 1023, 1023);
		send_item(dgr_pkg::CMD_CLEAR, 1023, 341);
		send_item(dgr_pkg::CMD_ADD_EDGE, 0, 0);
		send_item(dgr_pkg::CMD_ADD_EDGE, 1023, 682);
		send_item(dgr_pkg::CMD_EVALUATE, 0, 0);
		write_count(11'd0);
		send_item(dgr_pkg::CMD_EVALUATE, 0, 0);
		write_count(11'd1024);
		send_item(dgr_pkg::CMD_EVALUATE, 0, 0);
		write_count(11'd2047);
		send_item(dgr_pkg::CMD_ADD_EDGE, 0, 1023);
		send_item(dgr_pkg::CMD_EVALUATE, 0, 0);
		send_item(dgr_pkg::CMD_CLEAR, 0, 0);
	endtask

	// random graphs: mostly loads then evaluate, mostly small vertex counts
	task automatic test_random_graphs(int rounds);
		int unsigned n, ne;
		for (int r = 0; r < rounds; r++) begin
			if (r % 10 == 0) begin
				n = (r % 40 == 0) ? $urandom_range(1024, 2047) : $urandom_range(2, 24);
				write_count(n[10:0]);
				send_item(dgr_pkg::CMD_CLEAR, $urandom, $urandom);
			end
			if (n > NV) n = NV;
			ne = $urandom_range(1, 10);
			for (int e = 0; e < ne; e++) begin
				if ($urandom_range(19) == 0)
					send_item(2'($urandom_range(3)), $urandom, $urandom);
				else if ($urandom_range(9) == 0)
					send_item(dgr_pkg::CMD_ADD_EDGE, $urandom, $urandom);
				else
					send_item(dgr_pkg::CMD_ADD_EDGE, $urandom_range(n-1),
						$urandom_range(n > 20 ? n-1 : n+1));
			end
			send_item(dgr_pkg::CMD_EVALUATE, $urandom, $urandom);
			if ($urandom_range(4) == 0) send_item(dgr_pkg::CMD_CLEAR, $urandom, $urandom);
		end
	endtask

	// receiver holds off while evaluates pile up at the input
	task automatic test_backpressure();
		write_count(11'd6);
		snk_idle_en = 0;
		hold_cycles = 2000;
		@(posedge clk);
		for (int i = 0; i < 6; i++) send_item(dgr_pkg::CMD_EVALUATE, 0, 0);
		snk_idle_en = 1;
	endtask

	initial begin
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		m_axis_tready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		cycles = 0;
		errors = 0;
		hold_cycles = 0;
		src_idle_en = 0;
		snk_idle_en = 0;
		vcount = 11'd1;
		ovf = 0;
		for (int i = 0; i < NV; i++) deg[i] = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		src_idle_en = 1;
		snk_idle_en = 1;
		test_random_graphs(110);
		test_backpressure();
		test_random_graphs(50);
		drain();
		if (errors == 0) $display("Regression PASS");
		else $display("Regression FAIL");
		$finish;
	end

endmodule

// ----- digraph_reach_cycle_check.f -----
design/dgr_pkg.sv
design/dgr_ram.sv
design/dgr_ctrl.sv
design/digraph_reach_cycle_check.sv
test/tb_top.sv
